// File: hdl/sktbl_pkg.sv
// Package with the opcodes, status codes and sequencer states of the sorted key table.
package sktbl_pkg;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT_AT = 3'd1,
    OP_DELETE_AT = 3'd2,
    OP_READ      = 3'd3,
    OP_EXCHANGE  = 3'd4,
    OP_SORT      = 3'd5,
    OP_SEARCH    = 3'd6,
    OP_ORD_INS   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BADPOS = 3'd1,
    ST_DUP    = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REL_EQUAL = 2'd0,
    REL_BELOW = 2'd1,
    REL_ABOVE = 2'd2
  } rel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_READ_WAIT,
    S_XCHG_RD2,
    S_XCHG_WA,
    S_XCHG_WB,
    S_SORT_RD,
    S_SORT_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DONE
  } state_e;

endpackage

// File: hdl/sktbl_ram.sv
// Generic single-port RAM with registered read data.
module sktbl_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: hdl/sorted_key_table_engine_top.sv
// Top level of the sorted key table engine: sequencer around one key memory.
//
//   channel   direction  handshake              payload
//   input     in         in_valid_i/in_ready_o  opcode, positions, key, dup_allowed
//   result    out        out_valid_o/out_ready_i status, relation, index, value, count
//   config    in         cfg_we_i               cfg_wdata_i (signed_order)
//
// One transaction is worked on at a time; all table accesses go through a single
// memory port, one access per cycle. Insert and delete shift the entries one at a time,
// search is a binary search of about log2 of the count probes, and sort is an insertion
// sort. Reset empties the table at once by clearing the count; entries at or above the
// count are never read. A stalled result holds in the output registers while the
// sequencer waits in its done state.
module sorted_key_table_engine_top import sktbl_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [9:0]  position_i,
  input  logic [9:0]  second_position_i,
  input  logic [31:0] key_i,
  input  logic        dup_allowed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  relation_o,
  output logic [9:0]  index_o,
  output logic [31:0] value_o,
  output logic [10:0] count_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;
  logic   signed_q;

  // Captured transaction.
  op_e                  op_q, op_d;
  logic [9:0]           p1_q, p1_d, p2_q, p2_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 dup_q, dup_d;

  logic [CW-1:0] cnt_q, cnt_d;

  // Working registers: cursor, bounds, held data.
  logic [CW-1:0]        i_q, i_d, j_q, j_d;
  logic [CW-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [KEY_WIDTH-1:0] t_q, t_d;
  logic                 up_q, up_d;
  logic [1:0]           cmp_q, cmp_d;

  logic [2:0]  st_q, st_d;
  logic [1:0]  rel_q, rel_d;
  logic [9:0]  idx_q, idx_d;
  logic [31:0] val_q, val_d;

  logic                 we;
  logic [AW-1:0]        addr;
  logic [KEY_WIDTH-1:0] wdata, rdata;

  sktbl_ram #(.Width(KEY_WIDTH), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Three-way compare: 0 equal, 1 a below b, 2 a above b.
  function automatic logic [1:0] kcmp(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b,
                                      logic sgn);
    logic [KEY_WIDTH-1:0] x, y;
    x = a ^ {sgn, {(KEY_WIDTH-1){1'b0}}};
    y = b ^ {sgn, {(KEY_WIDTH-1){1'b0}}};
    if (x < y) return REL_BELOW;
    if (x > y) return REL_ABOVE;
    return REL_EQUAL;
  endfunction

  logic [10:0] n11;
  logic        full;
  assign n11  = 11'(cnt_q);
  assign full = n11 >= 11'(CAPACITY);

  always_comb begin
    state_d = state_q;
    op_d = op_q; p1_d = p1_q; p2_d = p2_q; key_d = key_q; dup_d = dup_q;
    cnt_d = cnt_q; i_d = i_q; j_d = j_q; lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    t_d = t_q; up_d = up_q; cmp_d = cmp_q;
    st_d = st_q; rel_d = rel_q; idx_d = idx_q; val_d = val_q;
    we = 1'b0; addr = '0; wdata = key_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = op_e'(opcode_i);
          p1_d  = position_i;
          p2_d  = second_position_i;
          key_d = KEY_WIDTH'(key_i);
          dup_d = dup_allowed_i;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        st_d = ST_OK; rel_d = REL_EQUAL; val_d = '0; idx_d = p1_q;
        state_d = S_DONE;
        case (op_q)
          OP_APPEND, OP_INSERT_AT: begin
            if (op_q == OP_APPEND) idx_d = 10'(cnt_q);
            if (op_q == OP_INSERT_AT && 11'(p1_q) > n11) st_d = ST_BADPOS;
            else if (full) st_d = ST_FULL;
            else begin
              p1_d = (op_q == OP_APPEND) ? 10'(cnt_q) : p1_q;
              i_d = cnt_q; up_d = 1'b1;
              state_d = S_SHIFT_RD;
            end
          end
          OP_DELETE_AT: begin
            if (11'(p1_q) >= n11) st_d = ST_BADPOS;
            else begin
              i_d = CW'(p1_q); up_d = 1'b0;
              state_d = S_SHIFT_RD;
            end
          end
          OP_READ: begin
            if (11'(p1_q) >= n11) st_d = ST_BADPOS;
            else begin
              addr = p1_q[AW-1:0];
              state_d = S_READ_WAIT;
            end
          end
          OP_EXCHANGE: begin
            if (11'(p1_q) >= n11 || 11'(p2_q) >= n11) st_d = ST_BADPOS;
            else begin
              addr = p1_q[AW-1:0];
              state_d = S_XCHG_RD2;
            end
          end
          OP_SORT: begin
            idx_d = '0;
            if (n11 >= 11'd2) begin
              i_d = CW'(1); j_d = CW'(1);
              state_d = S_SORT_RD;
            end
          end
          default: begin
            if (cnt_q == '0) begin
              idx_d = '0;
              if (op_q == OP_SEARCH) st_d = ST_EMPTY;
              else begin
                p1_d = '0; i_d = '0; up_d = 1'b1;
                state_d = S_SHIFT_RD;
              end
            end else begin
              lo_d = '0; hi_d = cnt_q - CW'(1);
              state_d = S_SRCH_RD;
            end
          end
        endcase
      end
      // Shift one entry per read and write; up_q moves entries to higher indexes.
      S_SHIFT_RD: begin
        if (up_q) begin
          if (11'(i_q) > 11'(p1_q)) begin
            addr = AW'(i_q - CW'(1));
            state_d = S_SHIFT_WR;
          end else begin
            we = 1'b1; addr = p1_q[AW-1:0]; wdata = key_q;
            cnt_d = cnt_q + CW'(1);
            state_d = S_DONE;
          end
        end else begin
          if (11'(i_q) + 11'd1 < n11) begin
            addr = AW'(i_q + CW'(1));
            state_d = S_SHIFT_WR;
          end else begin
            cnt_d = cnt_q - CW'(1);
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1; addr = AW'(i_q); wdata = rdata;
        i_d = up_q ? i_q - CW'(1) : i_q + CW'(1);
        state_d = S_SHIFT_RD;
      end
      S_READ_WAIT: begin
        val_d = 32'(rdata);
        state_d = S_DONE;
      end
      S_XCHG_RD2: begin
        t_d = rdata;                          // entry at first position
        addr = p2_q[AW-1:0];
        state_d = S_XCHG_WA;
      end
      S_XCHG_WA: begin
        // rdata holds the entry at the second position.
        we = 1'b1; addr = p1_q[AW-1:0]; wdata = rdata;
        state_d = S_XCHG_WB;
      end
      S_XCHG_WB: begin
        we = 1'b1; addr = p2_q[AW-1:0]; wdata = t_q;
        state_d = S_DONE;
      end
      // Insertion sort: j walks down while entry j-1 is above entry j.
      S_SORT_RD: begin
        if (i_q >= cnt_q) state_d = S_DONE;
        else if (j_q == '0) begin
          i_d = i_q + CW'(1); j_d = i_q + CW'(1);
        end else begin
          addr = AW'(j_q - CW'(1));
          state_d = S_SORT_CMP;
          lo_d = '0;
        end
      end
      // lo_q sequences the step: 0 take entry j-1, 1 compare with entry j,
      // 2 finish the swap by writing the held entry at j.
      S_SORT_CMP: begin
        if (lo_q == '0) begin
          t_d = rdata;                        // entry j-1
          addr = AW'(j_q);
          lo_d = CW'(1);
        end else if (lo_q == CW'(2)) begin
          we = 1'b1; addr = AW'(j_q); wdata = t_q;
          j_d = j_q - CW'(1);
          state_d = S_SORT_RD;
        end else if (kcmp(t_q, rdata, signed_q) == REL_ABOVE) begin
          we = 1'b1; addr = AW'(j_q - CW'(1)); wdata = rdata;
          lo_d = CW'(2);
        end else begin
          i_d = i_q + CW'(1); j_d = i_q + CW'(1);
          state_d = S_SORT_RD;
        end
      end
      S_SRCH_RD: begin
        mid_d = CW'((11'(lo_q) + 11'(hi_q)) >> 1);
        addr = AW'((11'(lo_q) + 11'(hi_q)) >> 1);
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmp_d = kcmp(key_q, rdata, signed_q);
        state_d = S_SRCH_RD;
        if (cmp_d == REL_BELOW) begin
          if (mid_q == '0 || mid_q - CW'(1) < lo_q) state_d = S_DONE;
          else hi_d = mid_q - CW'(1);
        end else if (cmp_d == REL_ABOVE) begin
          lo_d = mid_q + CW'(1);
          if (mid_q + CW'(1) > hi_q) state_d = S_DONE;
        end else state_d = S_DONE;
        if (state_d == S_DONE) begin
          idx_d = 10'(mid_q);
          if (op_q == OP_SEARCH) rel_d = cmp_d;
          else if (cmp_d == REL_EQUAL && !dup_q) st_d = ST_DUP;
          else begin
            idx_d = 10'((cmp_d == REL_ABOVE) ? mid_q + CW'(1) : mid_q);
            if (full) st_d = ST_FULL;
            else begin
              p1_d = (cmp_d == REL_ABOVE) ? 10'(mid_q + CW'(1)) : 10'(mid_q);
              i_d = cnt_q; up_d = 1'b1;
              state_d = S_SHIFT_RD;
            end
          end
        end
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      signed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) signed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; p1_q <= p1_d; p2_q <= p2_d; key_q <= key_d; dup_q <= dup_d;
    i_q <= i_d; j_q <= j_d; lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    t_q <= t_d; up_q <= up_d; cmp_q <= cmp_d;
    st_q <= st_d; rel_q <= rel_d; idx_q <= idx_d; val_q <= val_d;
  end

  assign status_o   = st_q;
  assign relation_o = rel_q;
  assign index_o    = idx_q;
  assign value_o    = val_q;
  assign count_o    = 11'(cnt_q);

  // The count never exceeds the capacity.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    11'(cnt_q) <= 11'(CAPACITY)) else $error("count above capacity");
  // The count holds while the block waits for a transaction.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (cnt_q == $past(cnt_q))) else $error("count changed in idle");
  // Input and result handshakes never overlap.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and result both open");
  // The memory is only written while a transaction is being worked on.
  a_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q != S_IDLE && state_q != S_DONE)) else $error("stray write");

endmodule

// File: tb/tb_sorted_key_table_engine_top.sv
// Self-checking testbench for the sorted key table engine, predictor and scoreboard.
module tb_sorted_key_table_engine_top;
  import sktbl_pkg::*;

  localparam int CAP = 256;
  localparam int WATCHDOG_LIMIT = 400000;

  // One result of the block, as carried on the output channel.
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  relation;
    logic [9:0]  index;
    logic [31:0] value;
    logic [10:0] count;
  } table_reply_t;

  // The scoreboard keeps its own copy of the key table and predicts every reply.
  class table_scoreboard;
    logic [31:0]  keys[CAP];
    int           used;
    bit           signed_cmp;
    table_reply_t pending[$];
    int           mismatches;

    function void clear();
      used = 0;
      signed_cmp = 0;
      pending.delete();
      mismatches = 0;
    endfunction

    // Returns -1, 0 or 1 as a orders below, equal to or above b.
    function int order_of(logic [31:0] a, logic [31:0] b);
      logic [31:0] x, y;
      x = signed_cmp ? {~a[31], a[30:0]} : a;
      y = signed_cmp ? {~b[31], b[30:0]} : b;
      if (x < y) return -1;
      return (x > y) ? 1 : 0;
    endfunction

    function void place(int pos, logic [31:0] k);
      for (int i = used; i > pos; i--) keys[i] = keys[i-1];
      keys[pos] = k;
      used++;
    endfunction

    // Works out the reply to one accepted request and queues it.
    function void note_request(op_e op, int p1, int p2, logic [31:0] k, bit dup);
      table_reply_t r;
      int n, lo, hi, mid, c;
      logic [31:0] t;
      r = '0;
      n = used;
      r.status = ST_OK;
      r.relation = REL_EQUAL;
      case (op)
        OP_APPEND: begin
          r.index = 10'(n);
          if (n >= CAP) r.status = ST_FULL;
          else place(n, k);
        end
        OP_INSERT_AT: begin
          r.index = 10'(p1);
          if (p1 > n) r.status = ST_BADPOS;
          else if (n >= CAP) r.status = ST_FULL;
          else place(p1, k);
        end
        OP_DELETE_AT: begin
          r.index = 10'(p1);
          if (p1 >= n) r.status = ST_BADPOS;
          else begin
            for (int i = p1; i + 1 < n; i++) keys[i] = keys[i+1];
            used = n - 1;
          end
        end
        OP_READ: begin
          r.index = 10'(p1);
          if (p1 >= n) r.status = ST_BADPOS;
          else r.value = keys[p1];
        end
        OP_EXCHANGE: begin
          r.index = 10'(p1);
          if (p1 >= n || p2 >= n) r.status = ST_BADPOS;
          else begin
            t = keys[p1];
            keys[p1] = keys[p2];
            keys[p2] = t;
          end
        end
        OP_SORT: begin
          for (int i = 1; i < n; i++)
            for (int j = i; j > 0 && order_of(keys[j-1], keys[j]) > 0; j--) begin
              t = keys[j-1];
              keys[j-1] = keys[j];
              keys[j] = t;
            end
        end
        default: begin
          if (n == 0) begin
            if (op == OP_SEARCH) r.status = ST_EMPTY;
            else place(0, k);
          end else begin
            lo = 0;
            hi = n - 1;
            mid = 0;
            c = 0;
            while (lo <= hi) begin
              mid = (lo + hi) >> 1;
              c = order_of(k, keys[mid]);
              if (c < 0) begin
                if (mid == 0) break;
                hi = mid - 1;
              end else if (c > 0) lo = mid + 1;
              else break;
            end
            if (op == OP_SEARCH) begin
              r.index = 10'(mid);
              r.relation = (c == 0) ? REL_EQUAL : (c < 0 ? REL_BELOW : REL_ABOVE);
            end else if (c == 0 && !dup) begin
              r.status = ST_DUP;
              r.index = 10'(mid);
            end else begin
              r.index = 10'((c > 0) ? mid + 1 : mid);
              if (n >= CAP) r.status = ST_FULL;
              else place(r.index, k);
            end
          end
        end
      endcase
      r.count = 11'(used);
      pending.push_back(r);
    endfunction

    function void check_reply(table_reply_t got);
      table_reply_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("reply mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [9:0]  position_i = '0;
  logic [9:0]  second_position_i = '0;
  logic [31:0] key_i = '0;
  logic        dup_allowed_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [1:0]  relation_o;
  logic [9:0]  index_o;
  logic [31:0] value_o;
  logic [10:0] count_o;

  table_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  bit finished = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_key_table_engine_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .opcode_i(opcode_i), .position_i(position_i),
    .second_position_i(second_position_i), .key_i(key_i),
    .dup_allowed_i(dup_allowed_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .status_o(status_o), .relation_o(relation_o), .index_o(index_o),
    .value_o(value_o), .count_o(count_o)
  );

  // Results are sampled at the edge where the transaction completes; the ready
  // toggling for the next cycle is drawn at the same edge, so it never changes
  // before the block has seen it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_reply({status_o, relation_o, index_o, value_o, count_o});
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog counts cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && !finished) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sends one request, with a random idle gap in front, and predicts its reply
  // at the edge where it is accepted. Valid stays high after the accepting edge
  // until the next request or an idle gap takes it over; the block is busy then.
  task automatic send_request(op_e op, int p1, int p2, logic [31:0] k, bit dup);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    position_i <= 10'(p1);
    second_position_i <= 10'(p2);
    key_i <= k;
    dup_allowed_i <= dup;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(op, p1, p2, k, dup);
  endtask

  // Waits for all replies, then lets the sequencer settle before a register write.
  task automatic drain_and_set_order(bit signed_cmp);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= signed_cmp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.signed_cmp = signed_cmp;
  endtask

  // Keys drawn from a small pool often collide, which exercises the duplicate paths;
  // the rest are fully random or sit at the signed extremes, next to the sign boundary.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(3))
      0: return 32'($urandom_range(15));
      1: return 32'h8000_0000 + $urandom_range(3) - 2;
      default: return $urandom();
    endcase
  endfunction

  // Positions mostly land inside the table, sometimes just past it, and rarely far out.
  function automatic int pick_pos();
    int n;
    n = board.used;
    case ($urandom_range(9))
      0: return $urandom_range(1023);
      1: return n;
      default: return (n == 0) ? 0 : $urandom_range(n - 1);
    endcase
  endfunction

  task automatic random_request();
    op_e op;
    int r;
    r = $urandom_range(99);
    // Keep the table mostly small so shifts and sorts stay short; inserts lose
    // their weight once it is half full.
    if (r < 40 && board.used > CAP / 2) op = OP_DELETE_AT;
    else if (r < 5) op = OP_SORT;
    else op = op_e'($urandom_range(7));
    if (op == OP_SORT && board.used > 40) op = OP_SEARCH;
    send_request(op, pick_pos(), pick_pos(), pick_key(), $urandom_range(1));
  endtask

  initial begin
    board.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty-table cases, every opcode, field extremes.
    send_request(OP_SEARCH, 0, 0, 32'h0, 1'b0);
    send_request(OP_SORT, 0, 0, 32'h0, 1'b0);
    send_request(OP_READ, 0, 0, 32'h0, 1'b0);
    send_request(OP_DELETE_AT, 1023, 0, 32'h0, 1'b0);
    send_request(OP_ORD_INS, 0, 0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_APPEND, 0, 0, 32'h8000_0000, 1'b0);
    send_request(OP_INSERT_AT, 0, 0, 32'h0000_0001, 1'b1);
    send_request(OP_INSERT_AT, 1023, 0, 32'h5, 1'b0);
    send_request(OP_EXCHANGE, 0, 1023, 32'h0, 1'b0);
    send_request(OP_EXCHANGE, 1023, 0, 32'h0, 1'b0);
    send_request(OP_EXCHANGE, 0, 2, 32'h0, 1'b0);
    send_request(OP_SORT, 0, 0, 32'h0, 1'b0);
    send_request(OP_SEARCH, 0, 0, 32'h0000_0001, 1'b0);
    send_request(OP_SEARCH, 0, 0, 32'h0, 1'b0);
    send_request(OP_SEARCH, 0, 0, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_ORD_INS, 0, 0, 32'h8000_0000, 1'b0);
    send_request(OP_ORD_INS, 0, 0, 32'h8000_0000, 1'b1);
    send_request(OP_READ, 2, 0, 32'h0, 1'b0);
    send_request(OP_DELETE_AT, 3, 0, 32'h0, 1'b0);

    // Signed order: re-sort the same keys and search across the sign boundary.
    drain_and_set_order(1'b1);
    send_request(OP_SORT, 0, 0, 32'h0, 1'b0);
    send_request(OP_SEARCH, 0, 0, 32'h7FFF_FFFF, 1'b0);
    send_request(OP_READ, 0, 0, 32'h0, 1'b0);

    // Fill the table to capacity to reach the full status, then delete back down to ten entries.
    while (board.used < CAP) send_request(OP_APPEND, 0, 0, $urandom(), 1'b0);
    send_request(OP_APPEND, 0, 0, 32'h1, 1'b0);
    send_request(OP_INSERT_AT, CAP, 0, 32'h1, 1'b0);
    send_request(OP_INSERT_AT, 0, 0, 32'h1, 1'b0);
    send_request(OP_ORD_INS, 0, 0, 32'h1, 1'b1);
    send_request(OP_READ, CAP - 1, 0, 32'h0, 1'b0);
    send_request(OP_DELETE_AT, CAP - 1, 0, 32'h0, 1'b0);
    while (board.used > 10) send_request(OP_DELETE_AT, board.used - 1, 0, 32'h0, 1'b0);

    // Random part in four idling phases, alternating the compare order.
    for (int phase = 0; phase < 4; phase++) begin
      drain_and_set_order(phase[0]);
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 33 : 47) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 33 : 47) : 0;
      for (int i = 0; i < 106; i++) random_request();
    end

    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    finished = 1;
    if (board.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
